/* hdl/clnw_pkg.sv */
// Shared types, codes and constants for the character LCD nibble writer.
package clnw_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [1:0]  KIND_CMD   = 2'd0;
    localparam logic [1:0]  KIND_CHAR  = 2'd1;
    localparam logic [1:0]  KIND_NUM   = 2'd2;

    localparam logic [7:0]  MINUS_CHAR = 8'd45;
    localparam logic [3:0]  ZERO_HIGH  = 4'h3;
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         byte_value;
        logic signed [31:0] number;
    } req_t;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
    } nib_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_PREP,
        ST_SEND_HI,
        ST_SEND_LO
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic load_num;
        logic conv_step;
        logic load_minus;
        logic pop;
        logic emit_hi;
        logic emit_lo;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic cnt_zero;
        logic out_free;
    } sts_t;

endpackage

/* hdl/clnw_ctrl.sv */
// Controller state machine sequencing conversion and nibble transfers.
module clnw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_kind,
    output logic               req_stall,
    input  clnw_pkg::sts_t     sts,
    output clnw_pkg::cmd_t     cmd
);
    import clnw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_kind inside {KIND_CMD, KIND_CHAR})
                    begin
                        cmd.load_byte = 1'b1;
                        state_next    = ST_SEND_HI;
                    end
                    else if (req_kind == KIND_NUM)
                    begin
                        cmd.load_num = 1'b1;
                        state_next   = ST_CONVERT;
                    end
                end
            end
            ST_CONVERT:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_done)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (sts.neg)
                begin
                    cmd.load_minus = 1'b1;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
                state_next = ST_SEND_HI;
            end
            ST_SEND_HI:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_hi = 1'b1;
                    state_next  = ST_SEND_LO;
                end
            end
            ST_SEND_LO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_lo = 1'b1;
                    if (sts.cnt_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_SEND_HI;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_hi || cmd.emit_lo) |-> sts.out_free)
        else $error("nibble emitted while output register busy");

    a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_hi |=> (state_reg == ST_SEND_LO))
        else $error("high nibble not followed by low nibble state");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load_byte, cmd.load_num, cmd.load_minus, cmd.pop}) <= 1)
        else $error("conflicting character loads");

endmodule

/* hdl/clnw_dpath.sv */
// Datapath: decimal digit extraction, digit buffer and nibble output register.
module clnw_dpath (
    input  logic           clk,
    input  logic           rst_n,
    input  clnw_pkg::req_t req,
    input  clnw_pkg::cmd_t cmd,
    output clnw_pkg::sts_t sts,
    output logic           nib_valid,
    input  logic           nib_stall,
    output clnw_pkg::nib_t nib
);
    import clnw_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [31:0]      mag_reg;
    logic             neg_reg;
    logic [7:0]       char_reg;
    logic             sel_reg;
    logic [3:0]       digit_reg [NUM_DIGITS];
    nib_t             out_reg;

    logic [63:0]      prod;
    logic [31:0]      quot;
    logic [31:0]      quot_x10;
    logic [31:0]      rem_full;
    logic [31:0]      num_mag;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] cnt_dec;

    assign prod     = {32'd0, mag_reg} * {32'd0, RECIP_TEN};
    assign quot     = {3'd0, prod[63:RECIP_SHIFT]};
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = mag_reg - quot_x10;
    assign num_mag  = req.number[31] ? (~req.number + 32'd1) : req.number;
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign wr_idx   = cnt_reg[IDX_W-1:0];
    assign rd_idx   = cnt_dec[IDX_W-1:0];

    assign sts.conv_done = (quot == 32'd0) || (cnt_reg == CNT_W'(NUM_DIGITS - 1));
    assign sts.neg       = neg_reg;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.out_free  = !out_valid_reg || !nib_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load_byte || cmd.load_num)
        begin
            cnt_next = '0;
        end
        else if (cmd.conv_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_dec;
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit_hi || cmd.emit_lo)
        begin
            out_valid_next = 1'b1;
        end
        else if (!nib_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            char_reg <= req.byte_value;
            sel_reg  <= (req.kind == KIND_CHAR);
        end
        if (cmd.load_num)
        begin
            mag_reg <= num_mag;
            neg_reg <= req.number[31];
            sel_reg <= 1'b1;
        end
        if (cmd.conv_step)
        begin
            digit_reg[wr_idx] <= rem_full[3:0];
            mag_reg           <= quot;
        end
        if (cmd.load_minus)
        begin
            char_reg <= MINUS_CHAR;
        end
        if (cmd.pop)
        begin
            char_reg <= {ZERO_HIGH, digit_reg[rd_idx]};
        end
        if (cmd.emit_hi)
        begin
            out_reg.register_select <= sel_reg;
            out_reg.nibble          <= char_reg[7:4];
            out_reg.last            <= 1'b0;
        end
        if (cmd.emit_lo)
        begin
            out_reg.register_select <= sel_reg;
            out_reg.nibble          <= char_reg[3:0];
            out_reg.last            <= (cnt_reg == '0);
        end
    end

    assign nib_valid = out_valid_reg;
    assign nib       = out_reg;

endmodule

/* hdl/char_lcd_nibble_writer_decimal_unit.sv */
// Top level of the character LCD 4-bit writer with decimal number printing.
//
//   channel  dir  payload  handshake
//   req      in   req_t    req_valid / req_stall
//   nib      out  nib_t    nib_valid / nib_stall
//
// A command or character item is loaded, then sent as a high and a low nibble.
// A number item is loaded, then converted digit by digit (up to 10 digits) through
// a single reciprocal-multiply divide-by-ten unit; after a setup step, each character
// (a leading minus sign first if negative) is sent as a high and a low nibble.
// Reset clears the state machine, digit count and output valid.
// A stall on nib holds the output register and the nibble sends; req waits until idle.
module char_lcd_nibble_writer_decimal_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  clnw_pkg::req_t req,
    output logic           nib_valid,
    input  logic           nib_stall,
    output clnw_pkg::nib_t nib
);
    import clnw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    clnw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    clnw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .nib_valid (nib_valid),
        .nib_stall (nib_stall),
        .nib       (nib)
    );

endmodule
